[sv/ppm_pkg.sv]
// Shared types, character codes and helper functions of the PPM stream parser.
`default_nettype none

package ppm_pkg;

   localparam int VALUE_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_P     = 8'h50;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   localparam logic [7:0] MODE_ASCII = 8'd3;
   localparam logic [7:0] MODE_RAW   = 8'd6;

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_PIXEL  = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       is_last;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  mode;
      logic [15:0] width;
      logic [15:0] height;
      logic [15:0] maxval;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        complete;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic         v0;
      rsp_item_type d0;
      logic         v1;
      rsp_item_type d1;
   } push_type;

   function automatic logic is_white(input logic [7:0] b);
      return (b == CHAR_LF) || (b == CHAR_CR) || (b == CHAR_TAB) || (b == CHAR_SPACE);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
   endfunction

endpackage

`default_nettype wire

[sv/ppm_if.sv]
// Valid/ready channel interfaces for the byte input and the result output.
`default_nettype none

interface ppm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       is_last;

   modport source (output valid, output in_byte, output is_last, input ready);
   modport sink (input valid, input in_byte, input is_last, output ready);
endinterface

interface ppm_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  mode;
   logic [15:0] width;
   logic [15:0] height;
   logic [15:0] maxval;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic        complete;
   logic        last;

   modport source (output valid, output kind, output mode, output width, output height,
                   output maxval, output red, output green, output blue, output complete,
                   output last, input ready);
   modport sink (input valid, input kind, input mode, input width, input height,
                 input maxval, input red, input green, input blue, input complete,
                 input last, output ready);
endinterface

`default_nettype wire

[sv/ppm_in_stage.sv]
// Input register that holds one accepted byte until the parser takes it.
`default_nettype none

module ppm_in_stage (
   input  wire                   clock,
   input  wire                   reset,
   ppm_req_if.sink               req_bus,
   input  wire                   take,
   output logic                  item_valid,
   output ppm_pkg::req_item_type item
);

   logic                  valid_ff;
   logic                  valid_in;
   ppm_pkg::req_item_type item_ff;
   logic                  accept;

   assign req_bus.ready = !valid_ff || take;
   assign accept = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.in_byte <= req_bus.in_byte;
         item_ff.is_last <= req_bus.is_last;
      end
   end

   assign item_valid = valid_ff;
   assign item = item_ff;

endmodule

`default_nettype wire

[sv/ppm_core.sv]
// Parser state machine: one byte per cycle in while the queue has room, up to two results out.
`default_nettype none

module ppm_core #(
   parameter int VALUE_BITS = ppm_pkg::VALUE_BITS_DEFAULT
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   take,
   input  ppm_pkg::req_item_type item,
   output ppm_pkg::push_type     push
);

   localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;
   localparam int STEP_BITS = VALUE_BITS + 4;
   localparam int PROD_BITS = 2 * VALUE_BITS;

   typedef enum logic [11:0] {
      PH_MAGIC = 12'b0000_0000_0001,
      PH_MODE  = 12'b0000_0000_0010,
      PH_W_GAP = 12'b0000_0000_0100,
      PH_W_TOK = 12'b0000_0000_1000,
      PH_H_GAP = 12'b0000_0001_0000,
      PH_H_TOK = 12'b0000_0010_0000,
      PH_M_GAP = 12'b0000_0100_0000,
      PH_M_TOK = 12'b0000_1000_0000,
      PH_RAW   = 12'b0001_0000_0000,
      PH_A_GAP = 12'b0010_0000_0000,
      PH_A_TOK = 12'b0100_0000_0000,
      PH_DONE  = 12'b1000_0000_0000
   } phase_type;

   function automatic logic [VALUE_BITS-1:0] digit_step(input logic [VALUE_BITS-1:0] acc,
                                                        input logic [7:0] b,
                                                        input logic sat);
      logic [STEP_BITS-1:0] t;
      logic [7:0]           d;
      d = b - ppm_pkg::CHAR_ZERO;
      t = (STEP_BITS'(acc) << 3) + (STEP_BITS'(acc) << 1) + STEP_BITS'(d);
      if (sat && (t > STEP_BITS'(VALUE_MAX))) begin
         return VALUE_MAX;
      end
      return t[VALUE_BITS-1:0];
   endfunction

   function automatic logic [15:0] sat16(input logic [VALUE_BITS-1:0] v);
      logic [31:0] e;
      e = 32'(v);
      return (e > 32'h0000_FFFF) ? 16'hFFFF : e[15:0];
   endfunction

   phase_type               phase_ff, phase_in;
   logic                    in_comment_ff, in_comment_in;
   logic [7:0]              image_mode_ff, image_mode_in;
   logic [VALUE_BITS-1:0]   accum_ff, accum_in;
   logic                    negative_ff, negative_in;
   logic                    digits_ended_ff, digits_ended_in;
   logic [VALUE_BITS-1:0]   width_ff, width_in;
   logic [VALUE_BITS-1:0]   height_ff, height_in;
   logic [VALUE_BITS-1:0]   maxval_ff, maxval_in;
   logic [31:0]             total_ff, total_in;
   logic [31:0]             count_ff, count_in;
   logic [1:0]              comp_ff, comp_in;
   logic [7:0]              held_red_ff, held_red_in;
   logic [7:0]              held_green_ff, held_green_in;
   logic [31:0]             product_ff, product_in;

   logic [PROD_BITS-1:0]    prod_wide;
   logic [63:0]             prod_ext;

   logic [7:0]              b;
   logic                    fin;
   logic                    white;
   logic                    digit;
   logic                    gap_start;
   logic                    comment_next;

   ppm_pkg::rsp_item_type   res_a;
   ppm_pkg::rsp_item_type   res_end;
   logic                    res_a_valid;

   assign b = item.in_byte;
   assign fin = item.is_last;
   assign white = ppm_pkg::is_white(b);
   assign digit = ppm_pkg::is_digit(b);

   // Pixel total is formed in its own register stage; height is registered in height_ff, and the
   // product in product_ff, before the maxval token can end.
   assign prod_wide = PROD_BITS'(width_ff) * PROD_BITS'(height_ff);
   assign prod_ext = 64'(prod_wide);
   assign product_in = (prod_ext[63:32] != 32'd0) ? 32'hFFFF_FFFF : prod_ext[31:0];

   always_comb begin
      gap_start = 1'b0;
      comment_next = in_comment_ff;
      if (in_comment_ff) begin
         if (b == ppm_pkg::CHAR_LF) begin
            comment_next = 1'b0;
         end
      end else if (white) begin
         gap_start = 1'b0;
      end else if (b == ppm_pkg::CHAR_HASH) begin
         comment_next = 1'b1;
      end else begin
         gap_start = 1'b1;
      end
   end

   always_comb begin
      logic                  tok_begin;
      logic                  tok_char;
      logic                  tok_sat;
      logic                  hdr_end;
      logic                  hdr_emitted;
      logic                  total_zero;
      logic                  do_comp;
      logic                  truncated;
      logic [VALUE_BITS-1:0] v;
      logic [7:0]            cv;
      logic [7:0]            neg_low;
      phase_type             ph;

      phase_in = phase_ff;
      in_comment_in = in_comment_ff;
      image_mode_in = image_mode_ff;
      accum_in = accum_ff;
      negative_in = negative_ff;
      digits_ended_in = digits_ended_ff;
      width_in = width_ff;
      height_in = height_ff;
      maxval_in = maxval_ff;
      total_in = total_ff;
      count_in = count_ff;
      comp_in = comp_ff;
      held_red_in = held_red_ff;
      held_green_in = held_green_ff;
      res_a = '0;
      res_a_valid = 1'b0;
      res_end = '0;
      tok_begin = 1'b0;
      tok_char = 1'b0;
      tok_sat = 1'b1;
      hdr_emitted = 1'b0;
      total_zero = 1'b0;
      truncated = 1'b0;
      v = '0;
      cv = '0;
      neg_low = '0;
      ph = phase_ff;

      unique case (phase_ff)
         PH_MAGIC: begin
            in_comment_in = comment_next;
            if (gap_start) begin
               if (b == ppm_pkg::CHAR_P) begin
                  phase_in = PH_MODE;
               end else begin
                  phase_in = PH_W_TOK;
                  tok_begin = 1'b1;
               end
            end
         end
         PH_MODE: begin
            image_mode_in = b - ppm_pkg::CHAR_ZERO;
            phase_in = PH_W_GAP;
         end
         PH_W_GAP, PH_H_GAP, PH_M_GAP: begin
            in_comment_in = comment_next;
            if (gap_start) begin
               tok_begin = 1'b1;
               if (phase_ff == PH_W_GAP) begin
                  phase_in = PH_W_TOK;
               end else if (phase_ff == PH_H_GAP) begin
                  phase_in = PH_H_TOK;
               end else begin
                  phase_in = PH_M_TOK;
               end
            end
         end
         PH_W_TOK, PH_H_TOK, PH_M_TOK: begin
            tok_char = !white;
         end
         PH_RAW: begin
         end
         PH_A_GAP: begin
            if (!white) begin
               phase_in = PH_A_TOK;
               tok_begin = 1'b1;
               tok_sat = 1'b0;
            end
         end
         PH_A_TOK: begin
            tok_char = !white;
            tok_sat = 1'b0;
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase

      if (tok_begin) begin
         accum_in = '0;
         negative_in = 1'b0;
         digits_ended_in = 1'b0;
         if (b == ppm_pkg::CHAR_MINUS) begin
            negative_in = 1'b1;
         end else if (b != ppm_pkg::CHAR_PLUS) begin
            if (digit) begin
               accum_in = VALUE_BITS'(b - ppm_pkg::CHAR_ZERO);
            end else begin
               digits_ended_in = 1'b1;
            end
         end
      end else if (tok_char && !digits_ended_ff) begin
         if (digit) begin
            accum_in = digit_step(accum_ff, b, tok_sat);
         end else begin
            digits_ended_in = 1'b1;
         end
      end

      // A header token ends on whitespace or on the final byte.
      hdr_end = ((phase_in == PH_W_TOK) || (phase_in == PH_H_TOK) || (phase_in == PH_M_TOK))
                && (white || fin);
      if (hdr_end) begin
         v = negative_in ? '0 : accum_in;
         ph = phase_in;
         if (ph == PH_W_TOK) begin
            width_in = v;
            phase_in = PH_H_GAP;
         end else if (ph == PH_H_TOK) begin
            height_in = v;
            phase_in = PH_M_GAP;
         end else begin
            maxval_in = v;
            hdr_emitted = 1'b1;
            total_zero = (width_in == '0) || (height_in == '0);
            res_a_valid = 1'b1;
            res_a.kind = ppm_pkg::KIND_HEADER;
            res_a.mode = image_mode_in;
            res_a.width = sat16(width_in);
            res_a.height = sat16(height_in);
            res_a.maxval = sat16(v);
            total_in = product_ff;
            count_in = '0;
            comp_in = '0;
            if (total_zero) begin
               phase_in = PH_DONE;
            end else if (image_mode_in == ppm_pkg::MODE_RAW) begin
               phase_in = PH_RAW;
            end else if (image_mode_in == ppm_pkg::MODE_ASCII) begin
               phase_in = PH_A_GAP;
            end else begin
               phase_in = PH_DONE;
            end
         end
      end

      do_comp = (phase_ff == PH_RAW) || ((phase_in == PH_A_TOK) && (white || fin));
      if (do_comp) begin
         neg_low = 8'd0 - accum_in[7:0];
         if (phase_ff == PH_RAW) begin
            cv = b;
         end else begin
            cv = negative_in ? neg_low : accum_in[7:0];
            phase_in = PH_A_GAP;
         end
         if (comp_ff == 2'd0) begin
            held_red_in = cv;
            comp_in = 2'd1;
         end else if (comp_ff == 2'd1) begin
            held_green_in = cv;
            comp_in = 2'd2;
         end else begin
            comp_in = 2'd0;
            res_a_valid = 1'b1;
            res_a.kind = ppm_pkg::KIND_PIXEL;
            res_a.red = held_red_ff;
            res_a.green = held_green_ff;
            res_a.blue = cv;
            count_in = count_ff + 32'd1;
            if (count_in >= total_ff) begin
               phase_in = PH_DONE;
            end
         end
      end

      if (fin) begin
         truncated = (phase_in == PH_MAGIC) || (phase_in == PH_MODE)
                     || (phase_in == PH_W_GAP) || (phase_in == PH_H_GAP)
                     || (phase_in == PH_M_GAP);
         if (truncated) begin
            res_a_valid = 1'b1;
            res_a.kind = ppm_pkg::KIND_HEADER;
            res_a.mode = image_mode_in;
            res_a.width = sat16(width_in);
            res_a.height = sat16(height_in);
            res_a.maxval = sat16(maxval_in);
         end
         res_end.kind = ppm_pkg::KIND_END;
         res_end.complete = !truncated && (hdr_emitted ? total_zero : (count_in == total_in));
         res_end.last = 1'b1;

         phase_in = PH_MAGIC;
         in_comment_in = 1'b0;
         image_mode_in = '0;
         accum_in = '0;
         negative_in = 1'b0;
         digits_ended_in = 1'b0;
         width_in = '0;
         height_in = '0;
         maxval_in = '0;
         total_in = '0;
         count_in = '0;
         comp_in = '0;
         held_red_in = '0;
         held_green_in = '0;
      end else begin
         res_a.last = 1'b1;
      end
   end

   always_comb begin
      push.v0 = take && (res_a_valid || fin);
      push.d0 = res_a_valid ? res_a : res_end;
      push.v1 = take && res_a_valid && fin;
      push.d1 = res_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MAGIC;
         in_comment_ff <= 1'b0;
         image_mode_ff <= '0;
         accum_ff <= '0;
         negative_ff <= 1'b0;
         digits_ended_ff <= 1'b0;
         width_ff <= '0;
         height_ff <= '0;
         maxval_ff <= '0;
         total_ff <= '0;
         count_ff <= '0;
         comp_ff <= '0;
         held_red_ff <= '0;
         held_green_ff <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         in_comment_ff <= in_comment_in;
         image_mode_ff <= image_mode_in;
         accum_ff <= accum_in;
         negative_ff <= negative_in;
         digits_ended_ff <= digits_ended_in;
         width_ff <= width_in;
         height_ff <= height_in;
         maxval_ff <= maxval_in;
         total_ff <= total_in;
         count_ff <= count_in;
         comp_ff <= comp_in;
         held_red_ff <= held_red_in;
         held_green_ff <= held_green_in;
      end
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

`default_nettype wire

[sv/ppm_out_queue.sv]
// Small result queue that takes up to two results per cycle and sends one when the receiver is ready.
`default_nettype none

module ppm_out_queue (
   input  wire               clock,
   input  wire               reset,
   input  ppm_pkg::push_type push,
   output logic              room,
   ppm_rsp_if.source         rsp_bus
);

   localparam int DEPTH = ppm_pkg::QUEUE_DEPTH;
   localparam int PTR_BITS = ppm_pkg::QUEUE_PTR_BITS;
   localparam int CNT_BITS = ppm_pkg::QUEUE_CNT_BITS;

   ppm_pkg::rsp_item_type q_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [PTR_BITS-1:0]   wr_next;
   logic                  pop;
   ppm_pkg::rsp_item_type head;

   assign pop = rsp_bus.valid && rsp_bus.ready;
   assign wr_next = wr_ptr_ff + PTR_BITS'(1);
   assign room = count_ff <= CNT_BITS'(DEPTH - 2);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(push.v0) + PTR_BITS'(push.v1);
      rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
      count_in = count_ff + CNT_BITS'(push.v0) + CNT_BITS'(push.v1) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.v0) begin
         q_ff[wr_ptr_ff] <= push.d0;
      end
      if (push.v1) begin
         q_ff[wr_next] <= push.d1;
      end
   end

   assign head = q_ff[rd_ptr_ff];

   assign rsp_bus.valid = count_ff != '0;
   assign rsp_bus.kind = head.kind;
   assign rsp_bus.mode = head.mode;
   assign rsp_bus.width = head.width;
   assign rsp_bus.height = head.height;
   assign rsp_bus.maxval = head.maxval;
   assign rsp_bus.red = head.red;
   assign rsp_bus.green = head.green;
   assign rsp_bus.blue = head.blue;
   assign rsp_bus.complete = head.complete;
   assign rsp_bus.last = head.last;

endmodule

`default_nettype wire

[sv/ppm_stream_parser.sv]
// An accepted byte is held in the input register until the queue has room, and its results are registered in the queue.
// Throughput: one byte per cycle while the queue has room; a byte that causes two results adds one more result to send.
// The rate is set by the parser update and the one-result-per-cycle queue read.
// Reset is synchronous and puts the parser in magic search with all header values zero.
// The last byte flushes any open token, emits the end result and returns to reset state.
// The parser keeps taking bytes while no more than two results wait in the queue.
`default_nettype none

module ppm_stream_parser #(
   parameter int VALUE_BITS = ppm_pkg::VALUE_BITS_DEFAULT
) (
   input  wire       clock,
   input  wire       reset,
   ppm_req_if.sink   req_bus,
   ppm_rsp_if.source rsp_bus
);

   logic                  stage_valid;
   ppm_pkg::req_item_type stage_item;
   logic                  room;
   logic                  take;
   ppm_pkg::push_type     push;

   assign take = stage_valid && room;

   ppm_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .take       (take),
      .item_valid (stage_valid),
      .item       (stage_item)
   );

   ppm_core #(
      .VALUE_BITS (VALUE_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .item  (stage_item),
      .push  (push)
   );

   ppm_out_queue u_out_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .room    (room),
      .rsp_bus (rsp_bus)
   );

   a_second_is_end: assert property (@(posedge clock) disable iff (reset)
      push.v1 |-> (push.v0 && (push.d1.kind == ppm_pkg::KIND_END)))
      else $error("Second result of a transfer is not an end result.");

   a_last_marks_final: assert property (@(posedge clock) disable iff (reset)
      push.v0 |-> (push.d0.last != push.v1))
      else $error("Last flag does not mark the final result of a transfer.");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.kind == ppm_pkg::KIND_END)) |-> rsp_bus.last)
      else $error("End result is not flagged as last.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("Result channel is valid right after reset.");

endmodule

`default_nettype wire

[bench/tb.sv]
// Self-checking testbench for the PPM stream parser: a table of files, then random files.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 2000;
   localparam int RANDOM_BYTES = 550;
   localparam int CALM_LENGTH = 150;

   typedef enum logic [3:0] {
      SCAN_MAGIC, SCAN_MODE, GAP_WIDTH, TOK_WIDTH, GAP_HEIGHT, TOK_HEIGHT,
      GAP_MAXVAL, TOK_MAXVAL, RAW_DATA, GAP_SAMPLE, TOK_SAMPLE, FILE_DONE
   } parse_phase_type;

   typedef struct {
      ppm_pkg::req_item_type item;
      int                    typed_count;
      ppm_pkg::rsp_item_type typed [2];
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic gaps_on = 1'b1;
   int   error_count = 0;
   int   quiet_cycles = 0;

   ppm_req_if req_bus ();
   ppm_rsp_if rsp_bus ();

   ppm_stream_parser dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   parse_phase_type parse_phase;
   logic            in_comment;
   logic [7:0]      file_mode;
   logic [15:0]     token_value;
   logic            token_negative;
   logic            token_closed;
   logic [15:0]     width_value;
   logic [15:0]     height_value;
   logic [15:0]     maxval_value;
   logic [31:0]     pixels_expected;
   logic [31:0]     pixels_seen;
   logic [1:0]      sample_index;
   logic [7:0]      red_sample;
   logic [7:0]      green_sample;

   ppm_pkg::rsp_item_type parse_results[$];
   stim_row_type          file_bytes[$];
   ppm_pkg::rsp_item_type seen_result;
   ppm_pkg::rsp_item_type wanted_result;

   function automatic ppm_pkg::rsp_item_type header_item(logic [7:0] mode, logic [15:0] w,
                                                         logic [15:0] h, logic [15:0] mv);
      ppm_pkg::rsp_item_type r;
      r = '0;
      r.kind = ppm_pkg::KIND_HEADER;
      r.mode = mode;
      r.width = w;
      r.height = h;
      r.maxval = mv;
      return r;
   endfunction

   function automatic ppm_pkg::rsp_item_type pixel_item(logic [7:0] red, logic [7:0] green,
                                                        logic [7:0] blue);
      ppm_pkg::rsp_item_type r;
      r = '0;
      r.kind = ppm_pkg::KIND_PIXEL;
      r.red = red;
      r.green = green;
      r.blue = blue;
      return r;
   endfunction

   function automatic ppm_pkg::rsp_item_type end_item(logic complete);
      ppm_pkg::rsp_item_type r;
      r = '0;
      r.kind = ppm_pkg::KIND_END;
      r.complete = complete;
      return r;
   endfunction

   function automatic string show_result(ppm_pkg::rsp_item_type r);
      return $sformatf("kind=%0d mode=%0d w=%0d h=%0d max=%0d rgb=%0d/%0d/%0d cmp=%0b last=%0b",
                       r.kind, r.mode, r.width, r.height, r.maxval, r.red, r.green,
                       r.blue, r.complete, r.last);
   endfunction

   // Parser state model.

   function automatic void clear_parser();
      parse_phase = SCAN_MAGIC;
      in_comment = 1'b0;
      file_mode = '0;
      token_value = '0;
      token_negative = 1'b0;
      token_closed = 1'b0;
      width_value = '0;
      height_value = '0;
      maxval_value = '0;
      pixels_expected = '0;
      pixels_seen = '0;
      sample_index = '0;
      red_sample = '0;
      green_sample = '0;
   endfunction

   function automatic logic is_blank(logic [7:0] b);
      return b == ppm_pkg::CHAR_LF || b == ppm_pkg::CHAR_CR || b == ppm_pkg::CHAR_TAB
             || b == ppm_pkg::CHAR_SPACE;
   endfunction

   function automatic logic header_gap_ends(logic [7:0] b);
      if (in_comment) begin
         if (b == ppm_pkg::CHAR_LF) in_comment = 1'b0;
         return 1'b0;
      end
      if (is_blank(b)) return 1'b0;
      if (b == ppm_pkg::CHAR_HASH) begin
         in_comment = 1'b1;
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void add_digit(logic [7:0] b, logic saturate);
      logic [63:0] t;
      if (token_closed) return;
      if (b < ppm_pkg::CHAR_ZERO || b > ppm_pkg::CHAR_NINE) begin
         token_closed = 1'b1;
         return;
      end
      t = 64'(token_value) * 64'd10 + 64'(b - ppm_pkg::CHAR_ZERO);
      if (saturate && t > 64'hFFFF) t = 64'hFFFF;
      token_value = t[15:0];
   endfunction

   function automatic void start_token(logic [7:0] b, logic saturate);
      token_value = '0;
      token_negative = 1'b0;
      token_closed = 1'b0;
      if (b == ppm_pkg::CHAR_MINUS) token_negative = 1'b1;
      else if (b != ppm_pkg::CHAR_PLUS) add_digit(b, saturate);
   endfunction

   function automatic void announce_header();
      pixels_expected = width_value * height_value;
      pixels_seen = '0;
      sample_index = '0;
      parse_results.push_back(header_item(file_mode, width_value, height_value, maxval_value));
   endfunction

   function automatic void close_header_token();
      logic [15:0] v;
      v = token_negative ? 16'd0 : token_value;
      case (parse_phase)
         TOK_WIDTH: begin
            width_value = v;
            parse_phase = GAP_HEIGHT;
         end
         TOK_HEIGHT: begin
            height_value = v;
            parse_phase = GAP_MAXVAL;
         end
         default: begin
            maxval_value = v;
            announce_header();
            if (pixels_expected == 0) parse_phase = FILE_DONE;
            else if (file_mode == ppm_pkg::MODE_RAW) parse_phase = RAW_DATA;
            else if (file_mode == ppm_pkg::MODE_ASCII) parse_phase = GAP_SAMPLE;
            else parse_phase = FILE_DONE;
         end
      endcase
   endfunction

   function automatic void take_sample(logic [7:0] v);
      if (sample_index == 2'd0) begin
         red_sample = v;
         sample_index = 2'd1;
      end else if (sample_index == 2'd1) begin
         green_sample = v;
         sample_index = 2'd2;
      end else begin
         sample_index = 2'd0;
         parse_results.push_back(pixel_item(red_sample, green_sample, v));
         pixels_seen++;
         if (pixels_seen >= pixels_expected) parse_phase = FILE_DONE;
      end
   endfunction

   function automatic void close_sample_token();
      logic [7:0] v;
      v = token_negative ? 8'(16'd0 - token_value) : token_value[7:0];
      parse_phase = GAP_SAMPLE;
      take_sample(v);
   endfunction

   function automatic void parse_byte(ppm_pkg::req_item_type it);
      int unsigned mark;
      logic        truncated;
      logic [7:0]  b;
      mark = parse_results.size();
      b = it.in_byte;
      case (parse_phase)
         SCAN_MAGIC: begin
            if (header_gap_ends(b)) begin
               if (b == ppm_pkg::CHAR_P) begin
                  parse_phase = SCAN_MODE;
               end else begin
                  parse_phase = TOK_WIDTH;
                  start_token(b, 1'b1);
               end
            end
         end
         SCAN_MODE: begin
            file_mode = b - ppm_pkg::CHAR_ZERO;
            parse_phase = GAP_WIDTH;
         end
         GAP_WIDTH, GAP_HEIGHT, GAP_MAXVAL: begin
            if (header_gap_ends(b)) begin
               parse_phase = parse_phase_type'(parse_phase + 1);
               start_token(b, 1'b1);
            end
         end
         TOK_WIDTH, TOK_HEIGHT, TOK_MAXVAL: begin
            if (is_blank(b)) close_header_token();
            else add_digit(b, 1'b1);
         end
         RAW_DATA: take_sample(b);
         GAP_SAMPLE: begin
            if (!is_blank(b)) begin
               parse_phase = TOK_SAMPLE;
               start_token(b, 1'b0);
            end
         end
         TOK_SAMPLE: begin
            if (is_blank(b)) close_sample_token();
            else add_digit(b, 1'b0);
         end
         default: ;
      endcase
      if (it.is_last) begin
         truncated = 1'b0;
         if (parse_phase == TOK_WIDTH || parse_phase == TOK_HEIGHT || parse_phase == TOK_MAXVAL)
            close_header_token();
         else if (parse_phase == TOK_SAMPLE)
            close_sample_token();
         if (parse_phase < RAW_DATA) begin
            truncated = 1'b1;
            announce_header();
         end
         parse_results.push_back(end_item(!truncated && pixels_seen == pixels_expected));
         clear_parser();
      end
      if (parse_results.size() > mark) parse_results[parse_results.size() - 1].last = 1'b1;
   endfunction

   // File construction.

   function automatic void add_row(logic [7:0] b, logic fin, int n = 0,
                                   ppm_pkg::rsp_item_type r0 = '0,
                                   ppm_pkg::rsp_item_type r1 = '0);
      stim_row_type row;
      row.item.in_byte = b;
      row.item.is_last = fin;
      row.typed_count = n;
      row.typed[0] = r0;
      row.typed[1] = r1;
      if (n > 0) row.typed[n - 1].last = 1'b1;
      file_bytes.push_back(row);
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) add_row(s[i], 1'b0);
   endfunction

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 3))
         0: return ppm_pkg::CHAR_LF;
         1: return ppm_pkg::CHAR_CR;
         2: return ppm_pkg::CHAR_TAB;
         default: return ppm_pkg::CHAR_SPACE;
      endcase
   endfunction

   function automatic void add_gap(logic leading);
      logic [7:0] c;
      if (!leading) add_row(pick_blank(), 1'b0);
      if ($urandom_range(0, 3) == 0) begin
         add_row(ppm_pkg::CHAR_HASH, 1'b0);
         repeat ($urandom_range(0, 4)) begin
            c = 8'($urandom_range(0, 255));
            if (c == ppm_pkg::CHAR_LF) c = ppm_pkg::CHAR_SPACE;
            add_row(c, 1'b0);
         end
         add_row(ppm_pkg::CHAR_LF, 1'b0);
      end
      if ($urandom_range(0, 1) == 1) add_row(pick_blank(), 1'b0);
   endfunction

   function automatic void add_number(int unsigned v, int unsigned odds);
      int unsigned r;
      r = $urandom_range(0, odds);
      if (r == 0) add_row(ppm_pkg::CHAR_MINUS, 1'b0);
      else if (r == 1) add_row(ppm_pkg::CHAR_PLUS, 1'b0);
      if (r == 2) add_text("x");
      else add_text($sformatf("%0d", v));
      if (r == 3) add_text("q7");
   endfunction

   function automatic int unsigned pick_size();
      case ($urandom_range(0, 19))
         0: return 0;
         1: return $urandom_range(65536, 999999);
         2: return 65535;
         default: return $urandom_range(1, 3);
      endcase
   endfunction

   function automatic void add_file();
      int unsigned start, magic, w, h, mv, pixel_count, target;
      start = file_bytes.size();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 12)) add_row(8'($urandom_range(0, 255)), 1'b0);
      end else begin
         add_gap(1'b1);
         magic = $urandom_range(0, 9);
         if (magic == 1) begin
            add_row(ppm_pkg::CHAR_P, 1'b0);
            add_row(8'($urandom_range(0, 255)), 1'b0);
         end else if (magic >= 2 && magic <= 4) begin
            add_text("P3");
         end else if (magic >= 5) begin
            add_text("P6");
         end
         if (magic != 0) add_gap(1'b1);
         w = pick_size();
         h = pick_size();
         case ($urandom_range(0, 7))
            0: mv = $urandom_range(65536, 32'hFFFFFFFF);
            1: mv = 65535;
            2: mv = $urandom_range(1, 65534);
            default: mv = 255;
         endcase
         add_number(w, 39);
         add_gap(1'b0);
         add_number(h, 39);
         add_gap(1'b0);
         add_number(mv, 39);
         pixel_count = (w <= 3 && h <= 3) ? w * h : $urandom_range(0, 3);
         if (magic >= 5) begin
            add_row(pick_blank(), 1'b0);
            repeat (3 * pixel_count) add_row(8'($urandom_range(0, 255)), 1'b0);
         end else if (magic >= 2) begin
            repeat (3 * pixel_count) begin
               add_row(pick_blank(), 1'b0);
               if ($urandom_range(0, 3) == 0) add_row(pick_blank(), 1'b0);
               add_number(($urandom_range(0, 7) == 0) ? $urandom_range(256, 100000)
                                                     : $urandom_range(0, 255), 11);
            end
            if ($urandom_range(0, 1) == 1) add_row(pick_blank(), 1'b0);
         end else begin
            add_row(pick_blank(), 1'b0);
         end
         if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 4)) add_row(8'($urandom_range(0, 255)), 1'b0);
         if ($urandom_range(0, 7) == 0) begin
            target = $urandom_range(start + 1, file_bytes.size());
            while (file_bytes.size() > target) void'(file_bytes.pop_back());
         end
      end
      file_bytes[file_bytes.size() - 1].item.is_last = 1'b1;
   endfunction

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= gaps_on ? ($urandom_range(0, 99) >= 34) : 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen_result = '{kind: rsp_bus.kind, mode: rsp_bus.mode, width: rsp_bus.width,
                         height: rsp_bus.height, maxval: rsp_bus.maxval, red: rsp_bus.red,
                         green: rsp_bus.green, blue: rsp_bus.blue,
                         complete: rsp_bus.complete, last: rsp_bus.last};
         if (parse_results.size() == 0) begin
            if (error_count < 10) $display("unexpected result: %s", show_result(seen_result));
            error_count++;
         end else begin
            wanted_result = parse_results.pop_front();
            if (seen_result.kind !== wanted_result.kind
                || seen_result.mode !== wanted_result.mode
                || seen_result.width !== wanted_result.width
                || seen_result.height !== wanted_result.height
                || seen_result.maxval !== wanted_result.maxval
                || seen_result.red !== wanted_result.red
                || seen_result.green !== wanted_result.green
                || seen_result.blue !== wanted_result.blue
                || seen_result.complete !== wanted_result.complete
                || seen_result.last !== wanted_result.last) begin
               if (error_count < 10)
                  $display("mismatch: expected %s, got %s", show_result(wanted_result),
                           show_result(seen_result));
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned mark;
      int          directed_count;
      int          calm_from;
      req_bus.valid <= 1'b0;
      req_bus.in_byte <= '0;
      req_bus.is_last <= 1'b0;
      clear_parser();

      // A lone zero byte as the whole file: truncated header of zeros.
      add_row(8'h00, 1'b1, 2, header_item(8'd0, 16'd0, 16'd0, 16'd0), end_item(1'b0));
      // Raw one-pixel file with a saturated maxval and sample bytes at both ends and the middle of the range.
      add_text("P6 1 1 99999");
      add_row(ppm_pkg::CHAR_LF, 1'b0, 1,
              header_item(ppm_pkg::MODE_RAW, 16'd1, 16'd1, 16'hFFFF));
      add_row(8'hFF, 1'b0);
      add_row(8'h00, 1'b0);
      add_row(8'h80, 1'b1, 2, pixel_item(8'hFF, 8'h00, 8'h80), end_item(1'b1));
      // No magic, negative width with junk, a comment, then a file cut off in height.
      add_text("-7#\n#x\n\r");
      add_row("5", 1'b1, 2, header_item(8'd0, 16'd0, 16'd5, 16'd0), end_item(1'b0));

      directed_count = file_bytes.size();
      while (file_bytes.size() - directed_count < RANDOM_BYTES) add_file();
      calm_from = directed_count + 200;

      @(posedge clock);
      while (reset) @(posedge clock);

      for (int idx = 0; idx < file_bytes.size(); idx++) begin
         gaps_on = !(idx >= calm_from && idx < calm_from + CALM_LENGTH);
         while (gaps_on && $urandom_range(0, 99) < 34) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
         req_bus.valid <= 1'b1;
         req_bus.in_byte <= file_bytes[idx].item.in_byte;
         req_bus.is_last <= file_bytes[idx].item.is_last;
         @(posedge clock);
         while (!req_bus.ready) @(posedge clock);
         // The transfer happened at this edge; update the model.
         mark = parse_results.size();
         parse_byte(file_bytes[idx].item);
         if (file_bytes[idx].typed_count > 0) begin
            while (parse_results.size() > mark) void'(parse_results.pop_back());
            for (int j = 0; j < file_bytes[idx].typed_count; j++)
               parse_results.push_back(file_bytes[idx].typed[j]);
         end
      end
      req_bus.valid <= 1'b0;
      gaps_on = 1'b1;

      while (parse_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
